[sv/wufe_pkg.sv]
package wufe_pkg;

  // Forest size; node indexes are taken as-is, so NODES is 1 << NODE_W.
  localparam int unsigned NODES  = 1024;
  localparam int unsigned NODE_W = $clog2(NODES);
  // Tree sizes and the set count reach NODES itself.
  localparam int unsigned SIZE_W = $clog2(NODES + 1);

  // Stream payload widths (fields packed from bit 0, padded to bytes).
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 32;

  // Output tdata field offsets.
  localparam int unsigned M_SAME_LSB  = 0;
  localparam int unsigned M_ROOTA_LSB = 1;
  localparam int unsigned M_ROOTB_LSB = M_ROOTA_LSB + NODE_W;
  localparam int unsigned M_COMP_LSB  = M_ROOTB_LSB + NODE_W;

  // Opcodes carried on s_axis_tuser.
  typedef enum logic {
    OP_UNION = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

endpackage

[sv/weighted_union_find_engine_core.sv]
// Weighted union-find engine. Keeps a disjoint-set forest over NODES nodes
// in two single-port-write RAMs (parent table and tree size). Each input beat
// names two nodes and an opcode on tuser (0 = union, 1 = connected query);
// both roots are found by path halving, which rewrites parent entries on the
// way, and a union links the smaller tree under the larger one (ties put
// node_b's root under node_a's). Every input beat yields exactly one output
// beat with both roots, the same-set flag (roots equal before the step) and
// the set count after the step. After reset the block runs a clearing pass
// over all NODES entries that loads every parent entry with its own index
// and every size with one; s_axis_tready stays low until it ends. Root
// walks are bound by the parent RAM: one registered read per cycle, two
// reads per hop (parent, then grandparent). The block takes one item at a
// time; a finished result sits in the output register while the next item
// is already accepted.
module weighted_union_find_engine_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [wufe_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // node_a[9:0], node_b[19:10], 0
  input  logic                             s_axis_tuser,  // opcode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [wufe_pkg::M_TDATA_W-1:0]   m_axis_tdata   // same_set[0], root_a[10:1],
                                                          // root_b[20:11],
                                                          // components_left[31:21]
);

  import wufe_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,   // reset sweep over both RAMs
    ST_IDLE,
    ST_FA_RD,   // issue read of parent[walk]
    ST_FA_P,    // parent in hand: root test, else fetch grandparent
    ST_FA_GP,   // grandparent in hand: halve the path, step up
    ST_LK_A,    // read size[root_a]
    ST_LK_B,    // read size[root_b], capture size[root_a]
    ST_LK_UPD,  // compare sizes, link and grow
    ST_DONE     // hand result to the output register
  } state_e;

  state_e            state_q;
  logic [NODE_W-1:0] clr_q;
  logic              op_q;
  logic              sel_b_q;     // 0: walking node_a, 1: walking node_b
  logic [NODE_W-1:0] nb_q;
  logic [NODE_W-1:0] walk_q;
  logic [NODE_W-1:0] ra_q;
  logic [NODE_W-1:0] rb_q;
  logic              same_q;
  logic [SIZE_W-1:0] sa_q;
  logic [SIZE_W-1:0] comp_q;

  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  // RAM ports
  logic              par_we;
  logic [NODE_W-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
  logic              siz_we;
  logic [NODE_W-1:0] siz_waddr, siz_raddr;
  logic [SIZE_W-1:0] siz_wdata, siz_rdata;

  // Shared datapath pieces
  logic              at_root;
  logic              a_smaller;
  logic [SIZE_W-1:0] size_sum;
  logic              s_fire;
  logic              out_free;

  assign at_root   = (par_rdata == walk_q);
  assign a_smaller = (sa_q < siz_rdata);
  assign size_sum  = sa_q + siz_rdata;
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // RAM control, decoded from the sequencer state
  always_comb begin
    par_we    = 1'b0;
    par_waddr = walk_q;
    par_wdata = par_rdata;
    par_raddr = walk_q;
    siz_we    = 1'b0;
    siz_waddr = ra_q;
    siz_wdata = size_sum;
    siz_raddr = ra_q;
    case (state_q)
      ST_CLEAR: begin
        par_we    = 1'b1;
        par_waddr = clr_q;
        par_wdata = clr_q;
        siz_we    = 1'b1;
        siz_waddr = clr_q;
        siz_wdata = SIZE_W'(1);
      end
      ST_FA_P: begin
        par_raddr = par_rdata;
      end
      ST_FA_GP: begin
        // parent[walk] <= grandparent, then continue from it
        par_we    = 1'b1;
        par_raddr = par_rdata;
      end
      ST_LK_B: begin
        siz_raddr = rb_q;
      end
      ST_LK_UPD: begin
        par_we = 1'b1;
        siz_we = 1'b1;
        if (a_smaller) begin
          par_waddr = ra_q;
          par_wdata = rb_q;
          siz_waddr = rb_q;
        end else begin
          par_waddr = rb_q;
          par_wdata = ra_q;
          siz_waddr = ra_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      comp_q    <= SIZE_W'(NODES);
      m_valid_q <= 1'b0;
      sel_b_q   <= 1'b0;
    end else begin
      // output slot: a new result may replace a beat taken this cycle
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + NODE_W'(1);
          if (clr_q == NODE_W'(NODES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            op_q    <= s_axis_tuser;
            walk_q  <= s_axis_tdata[NODE_W-1:0];
            nb_q    <= s_axis_tdata[2*NODE_W-1:NODE_W];
            sel_b_q <= 1'b0;
            state_q <= ST_FA_RD;
          end
        end
        ST_FA_RD: begin
          state_q <= ST_FA_P;
        end
        ST_FA_P: begin
          if (at_root) begin
            if (!sel_b_q) begin
              ra_q    <= walk_q;
              walk_q  <= nb_q;
              sel_b_q <= 1'b1;
              state_q <= ST_FA_RD;
            end else begin
              rb_q   <= walk_q;
              same_q <= (ra_q == walk_q);
              if (op_q == OP_UNION && ra_q != walk_q) begin
                state_q <= ST_LK_A;
              end else begin
                state_q <= ST_DONE;
              end
            end
          end else begin
            state_q <= ST_FA_GP;
          end
        end
        ST_FA_GP: begin
          walk_q  <= par_rdata;
          state_q <= ST_FA_P;
        end
        ST_LK_A: begin
          state_q <= ST_LK_B;
        end
        ST_LK_B: begin
          sa_q    <= siz_rdata;
          state_q <= ST_LK_UPD;
        end
        ST_LK_UPD: begin
          if (comp_q > SIZE_W'(1)) begin
            comp_q <= comp_q - SIZE_W'(1);
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_data_q  <= {comp_q, rb_q, ra_q, same_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  wufe_ram #(
    .WIDTH(NODE_W),
    .DEPTH(NODES)
  ) u_parent_ram (
    .clk_i  (clk_i),
    .we_i   (par_we),
    .waddr_i(par_waddr),
    .wdata_i(par_wdata),
    .raddr_i(par_raddr),
    .rdata_o(par_rdata)
  );

  wufe_ram #(
    .WIDTH(SIZE_W),
    .DEPTH(NODES)
  ) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (siz_we),
    .waddr_i(siz_waddr),
    .wdata_i(siz_wdata),
    .raddr_i(siz_raddr),
    .rdata_o(siz_rdata)
  );

endmodule

[sv/wufe_ram.sv]
module wufe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Registered read, old data on a same-address collision.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/wufe_checker.sv]
module wufe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [wufe_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  import wufe_pkg::*;

  logic [NODE_W-1:0] root_a, root_b;
  logic [SIZE_W-1:0] comps;

  assign root_a = m_axis_tdata[M_ROOTA_LSB +: NODE_W];
  assign root_b = m_axis_tdata[M_ROOTB_LSB +: NODE_W];
  assign comps  = m_axis_tdata[M_COMP_LSB +: SIZE_W];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted back to back");

  // same-set flag agrees with the reported roots
  a_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[M_SAME_LSB] == (root_a == root_b)))
    else $error("same_set disagrees with roots");

  // set count stays within 1..NODES
  a_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (comps != '0) && (comps <= SIZE_W'(NODES)))
    else $error("component count out of range");

endmodule

bind weighted_union_find_engine_core wufe_checker u_wufe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
